// ----- sv/linear_gradient_line_endpoints_core_macros.svh -----
// Assertion macros shared by the checker of the gradient line endpoint core.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LINEAR_GRADIENT_LINE_ENDPOINTS_CORE_MACROS_SVH
`define LINEAR_GRADIENT_LINE_ENDPOINTS_CORE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define LGLE_AST_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define LGLE_AST_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication that is checked during reset as well.
`define LGLE_AST_ALWAYS(lbl, clk_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/lgle_pkg.sv -----
// Shared types, constants and tables of the gradient line endpoint core.
// No dependencies; imported by every module of the core but lgle_queue.
`timescale 1ns / 1ps
`default_nettype none

package lgle_pkg;

    localparam int SIZE_BITS_DEF   = 12;
    localparam int ANGLE_STEPS_DEF = 16;

    localparam int KIND_W   = 4;
    localparam int SIZE_W   = 12;
    localparam int ANGLE_W  = 13;
    localparam int COUNT_W  = 5;
    localparam int COORD_W  = 18;

    localparam int COORD_MAX = 131071;
    localparam int COORD_MIN = -131072;

    localparam int CORDIC_STEPS = 17;
    localparam int CORDIC_GAIN  = 652032874;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [KIND_W-1:0] {
        DIR_ANGLE    = 4'd0,
        DIR_TOP      = 4'd1,
        DIR_BOTTOM   = 4'd2,
        DIR_LEFT     = 4'd3,
        DIR_RIGHT    = 4'd4,
        DIR_TOPRIGHT = 4'd5,
        DIR_TOPLEFT  = 4'd6,
        DIR_BOTRIGHT = 4'd7,
        DIR_BOTLEFT  = 4'd8
    } dir_t;

    // Classified item as it leaves the front end.
    typedef struct packed {
        logic               ok;
        dir_t               dir;
        logic [ANGLE_W-1:0] ang;
        logic               sin_pos;
        logic               cos_pos;
    } cls_t;

    // Arctangent of 2^-i in units of 2^-20 degree.
    function automatic longint atan_q20(input int i);
        longint r;
        r = 0;
        case (i)
            0:  r = 47185920;
            1:  r = 27855475;
            2:  r = 14718068;
            3:  r = 7471121;
            4:  r = 3750058;
            5:  r = 1876857;
            6:  r = 938658;
            7:  r = 469358;
            8:  r = 234683;
            9:  r = 117342;
            10: r = 58671;
            11: r = 29336;
            12: r = 14668;
            13: r = 7334;
            14: r = 3667;
            15: r = 1833;
            16: r = 917;
            default: r = 0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/lgle_queue.sv -----
// Small first-in first-out queue between the front end and the back end.
// Depends on nothing; generic in width and depth.
`timescale 1ns / 1ps
`default_nettype none

module lgle_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]      cnt_reg, cnt_next;

    assign full      = (cnt_reg == (PW+1)'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rd_data   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (wr_en)
        begin
            wp_next = (wp_reg == PW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
        end
        if (rd_en)
        begin
            rp_next = (rp_reg == PW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lgle_front.sv -----
// Front end: takes input beats, checks the counts, decodes the direction
// and reduces the angle into one turn. Depends on lgle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgle_front
    import lgle_pkg::*;
#(
    parameter int SIZE_BITS              = SIZE_BITS_DEF,
    parameter int ANGLE_STEPS_PER_DEGREE = ANGLE_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [KIND_W-1:0]  kind,
    input  wire logic [SIZE_W-1:0]  box_width,
    input  wire logic [SIZE_W-1:0]  box_height,
    input  wire logic [ANGLE_W-1:0] angle,
    input  wire logic [COUNT_W-1:0] color_count,
    input  wire logic [COUNT_W-1:0] stop_count,
    input  wire logic               q_full,
    output logic                    q_push,
    output cls_t                    cls,
    output logic [SIZE_BITS-1:0]    w,
    output logic [SIZE_BITS-1:0]    h
);

    localparam int P         = ANGLE_STEPS_PER_DEGREE;
    localparam int FULL      = 360 * P;
    localparam int HALF      = 180 * P;
    localparam int QTR       = 90 * P;
    localparam int MAX_TURNS = ((1 << ANGLE_W) - 1) / FULL;
    localparam int RED_STEPS = $clog2(MAX_TURNS + 1);

    logic                 v_reg, v_next;
    cls_t                 cls_reg, cls_next;
    logic [SIZE_BITS-1:0] w_reg, w_next, h_reg, h_next;
    logic                 take;

    assign full   = v_reg && q_full;
    assign take   = push && !full;
    assign q_push = v_reg && !q_full;
    assign cls    = cls_reg;
    assign w      = w_reg;
    assign h      = h_reg;

    always_comb
    begin
        logic [ANGLE_W-1:0] ar;
        ar = angle;
        // Binary long reduction: subtract the largest multiples of a turn first.
        for (int k = RED_STEPS - 1; k >= 0; k--)
        begin
            if (ar >= ANGLE_W'(FULL << k))
            begin
                ar = ar - ANGLE_W'(FULL << k);
            end
        end
        cls_next.ang     = ar;
        cls_next.sin_pos = (32'(ar) <= HALF);
        cls_next.cos_pos = (32'(ar) <= QTR) || (32'(ar) >= 3 * QTR);
        cls_next.ok      = (color_count >= COUNT_W'(2)) &&
                           ((stop_count == '0) || (stop_count == color_count));
        if ((kind >= KIND_W'(DIR_TOP)) && (kind <= KIND_W'(DIR_BOTLEFT)))
        begin
            cls_next.dir = dir_t'(kind);
        end
        else
        begin
            cls_next.dir = DIR_ANGLE;
        end
        w_next = SIZE_BITS'(box_width);
        h_next = SIZE_BITS'(box_height);
        if (w_next == '0)
        begin
            w_next = SIZE_BITS'(1);
        end
        if (h_next == '0)
        begin
            h_next = SIZE_BITS'(1);
        end
        v_next = take ? 1'b1 : (q_push ? 1'b0 : v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cls_reg <= cls_next;
            w_reg   <= w_next;
            h_reg   <= h_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lgle_back.sv -----
// Back end: pipelined CORDIC and restoring dividers, then the endpoint
// arithmetic and the result register. Depends on lgle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgle_back
    import lgle_pkg::*;
#(
    parameter int SIZE_BITS              = SIZE_BITS_DEF,
    parameter int ANGLE_STEPS_PER_DEGREE = ANGLE_STEPS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_take,
    input  wire cls_t                      cls,
    input  wire logic [SIZE_BITS-1:0]      w,
    input  wire logic [SIZE_BITS-1:0]      h,
    output logic                           empty,
    input  wire logic                      pop,
    output logic                           gradient_valid,
    output logic signed [COORD_W-1:0]      start_x,
    output logic signed [COORD_W-1:0]      start_y,
    output logic signed [COORD_W-1:0]      end_x,
    output logic signed [COORD_W-1:0]      end_y
);

    localparam int SW   = SIZE_BITS;
    localparam int P    = ANGLE_STEPS_PER_DEGREE;
    localparam int FULL = 360 * P;
    localparam int HALF = 180 * P;
    localparam int QTR  = 90 * P;
    localparam int AW2  = $clog2(FULL) + 1;
    localparam int BW   = $clog2(HALF + 1) + 1;
    localparam int ZW   = $clog2(P) + 30;
    localparam int XW   = 34;
    localparam int DNW  = 2 * SW + 1;
    localparam int DW   = 2 * SW + 2;
    localparam int NW   = 3 * SW + 7;
    localparam int QB   = SW + 4;
    localparam int NS   = (QB > CORDIC_STEPS) ? QB : CORDIC_STEPS;
    localparam int CW   = SW + 5;
    localparam int PW   = CW + 17;
    localparam int TW   = PW + 1;
    localparam int STW  = TW + 17;
    localparam int EW   = (SW + 8 > 19) ? SW + 8 : 19;

    localparam logic signed [AW2-1:0] FULL_S = AW2'(FULL);
    localparam logic signed [AW2-1:0] HALF_S = AW2'(HALF);
    localparam logic signed [AW2-1:0] QTR_S  = AW2'(QTR);
    localparam logic signed [ZW-1:0]  ZLIM   = ZW'(-P);
    localparam logic signed [XW-1:0]  QMAX   = XW'(32768);
    localparam logic signed [XW-1:0]  QMIN   = XW'(-32768);
    localparam logic signed [XW-1:0]  HALFQ  = XW'(16384);
    localparam logic signed [STW-1:0] RND    = STW'(64'sd536870912);
    localparam logic signed [EW-1:0]  SMAX   = EW'(COORD_MAX);
    localparam logic signed [EW-1:0]  SMIN   = EW'(COORD_MIN);

    typedef struct packed {
        logic                   ok;
        dir_t                   dir;
        logic                   sin_pos;
        logic                   cos_pos;
        logic [ANGLE_W-1:0]     ang;
        logic [SW-1:0]          w;
        logic [SW-1:0]          h;
        logic                   neg;
        logic signed [BW-1:0]   b;
        logic [2*SW-1:0]        wh;
        logic [DNW-1:0]         den;
    } pre_t;

    typedef struct packed {
        logic                   ok;
        dir_t                   dir;
        logic                   sin_pos;
        logic                   cos_pos;
        logic                   neg;
        logic                   bneg;
        logic [SW-1:0]          w;
        logic [SW-1:0]          h;
        logic signed [ZW-1:0]   zp;
        logic signed [XW-1:0]   x;
        logic signed [XW-1:0]   y;
        logic [NW-1:0]          rh;
        logic [NW-1:0]          rw;
        logic [DW-1:0]          d2;
        logic [QB-1:0]          qh;
        logic [QB-1:0]          qw;
    } it_t;

    typedef struct packed {
        logic                   ok;
        dir_t                   dir;
        logic                   sin_pos;
        logic                   cos_pos;
        logic [SW-1:0]          w;
        logic [SW-1:0]          h;
        logic [QB-1:0]          qh;
        logic [QB-1:0]          qw;
        logic signed [16:0]     c;
        logic signed [16:0]     s;
        logic signed [PW-1:0]   p1;
        logic signed [PW-1:0]   p2;
        logic signed [TW-1:0]   t;
        logic signed [STW-1:0]  st;
        logic signed [STW-1:0]  ct;
    } post_t;

    logic  adv;
    logic  va_reg, vb_reg, out_v_reg;
    logic  v_it_reg [NS+1];
    logic  v_po_reg [4];
    pre_t  a_reg, b_reg, b_next;
    it_t   it_reg [NS+1];
    it_t   c_next;
    post_t po_reg [4];
    post_t r1_next, r2_next, r3_next, r4_next;

    logic                      gv_next;
    logic signed [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [COORD_W-1:0] sx_next, sy_next, ex_next, ey_next;

    // The whole pipeline moves together; it halts only while a result waits.
    assign adv     = !out_v_reg || pop;
    assign in_take = adv && in_valid;
    assign empty   = !out_v_reg;

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] r;
        r = v;
        if (v > SMAX)
        begin
            r = SMAX;
        end
        else if (v < SMIN)
        begin
            r = SMIN;
        end
        return COORD_W'(r);
    endfunction

    // Stage B: fold the angle into the right half plane, form w*h and w^2+h^2.
    always_comb
    begin
        logic signed [AW2-1:0] as, bt;
        b_next     = a_reg;
        as         = AW2'($signed({1'b0, a_reg.ang}));
        bt         = (as > HALF_S) ? as - FULL_S : as;
        b_next.neg = 1'b0;
        if (bt > QTR_S)
        begin
            bt         = bt - HALF_S;
            b_next.neg = 1'b1;
        end
        else if (bt < -QTR_S)
        begin
            bt         = bt + HALF_S;
            b_next.neg = 1'b1;
        end
        b_next.b   = BW'(bt);
        b_next.wh  = (2*SW)'(a_reg.w) * (2*SW)'(a_reg.h);
        b_next.den = DNW'(a_reg.w) * DNW'(a_reg.w) + DNW'(a_reg.h) * DNW'(a_reg.h);
    end

    // Stage C: dividends, divisor and the CORDIC start vector.
    always_comb
    begin
        c_next.ok      = b_reg.ok;
        c_next.dir     = b_reg.dir;
        c_next.sin_pos = b_reg.sin_pos;
        c_next.cos_pos = b_reg.cos_pos;
        c_next.neg     = b_reg.neg;
        c_next.bneg    = b_reg.b < 0;
        c_next.w       = b_reg.w;
        c_next.h       = b_reg.h;
        // The angle stays scaled by the step count; the arctangents are scaled to match.
        c_next.zp      = ZW'(b_reg.b) <<< 20;
        c_next.x       = XW'(CORDIC_GAIN);
        c_next.y       = '0;
        c_next.rh      = ((NW'(b_reg.wh) * NW'(b_reg.h)) << 6) + NW'(b_reg.den);
        c_next.rw      = ((NW'(b_reg.wh) * NW'(b_reg.w)) << 6) + NW'(b_reg.den);
        c_next.d2      = DW'(b_reg.den) << 1;
        c_next.qh      = '0;
        c_next.qw      = '0;
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_iter
        localparam bit DO_ROT = (i < CORDIC_STEPS);
        localparam bit DO_DIV = (i < QB);
        localparam int K      = DO_DIV ? (QB - 1 - i) : 0;
        localparam logic signed [ZW-1:0] ATP = ZW'(longint'(P) * atan_q20(i));

        it_t nx;

        always_comb
        begin
            logic zge;
            nx = it_reg[i];
            // With the angle kept scaled, a truncated quotient test becomes an offset test.
            zge = it_reg[i].bneg ? (it_reg[i].zp > ZLIM) : (it_reg[i].zp >= 0);
            if (DO_ROT)
            begin
                if (zge)
                begin
                    nx.x  = it_reg[i].x - (it_reg[i].y >>> i);
                    nx.y  = it_reg[i].y + (it_reg[i].x >>> i);
                    nx.zp = it_reg[i].zp - ATP;
                end
                else
                begin
                    nx.x  = it_reg[i].x + (it_reg[i].y >>> i);
                    nx.y  = it_reg[i].y - (it_reg[i].x >>> i);
                    nx.zp = it_reg[i].zp + ATP;
                end
            end
            if (DO_DIV)
            begin
                if ((it_reg[i].rh >> K) >= NW'(it_reg[i].d2))
                begin
                    nx.rh    = it_reg[i].rh - (NW'(it_reg[i].d2) << K);
                    nx.qh[K] = 1'b1;
                end
                if ((it_reg[i].rw >> K) >= NW'(it_reg[i].d2))
                begin
                    nx.rw    = it_reg[i].rw - (NW'(it_reg[i].d2) << K);
                    nx.qw[K] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_it_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_it_reg[i+1] <= v_it_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                it_reg[i+1] <= nx;
            end
        end
    end

    // R1: undo the half-turn fold and round sine and cosine to Q15.
    always_comb
    begin
        logic signed [XW-1:0] xs, ys, xr, yr;
        xs = it_reg[NS].neg ? -it_reg[NS].x : it_reg[NS].x;
        ys = it_reg[NS].neg ? -it_reg[NS].y : it_reg[NS].y;
        xr = (xs + HALFQ) >>> 15;
        yr = (ys + HALFQ) >>> 15;
        if (xr > QMAX)
        begin
            xr = QMAX;
        end
        else if (xr < QMIN)
        begin
            xr = QMIN;
        end
        if (yr > QMAX)
        begin
            yr = QMAX;
        end
        else if (yr < QMIN)
        begin
            yr = QMIN;
        end
        r1_next         = po_reg[0];
        r1_next.ok      = it_reg[NS].ok;
        r1_next.dir     = it_reg[NS].dir;
        r1_next.sin_pos = it_reg[NS].sin_pos;
        r1_next.cos_pos = it_reg[NS].cos_pos;
        r1_next.w       = it_reg[NS].w;
        r1_next.h       = it_reg[NS].h;
        r1_next.qh      = it_reg[NS].qh;
        r1_next.qw      = it_reg[NS].qw;
        r1_next.c       = 17'(xr);
        r1_next.s       = 17'(yr);
    end

    // R2: the two products of the line parameter; the signs of the sides are picked by quadrant.
    always_comb
    begin
        logic signed [CW-1:0] cyv, cxv;
        cyv        = $signed({2'b00, po_reg[0].h, 3'b000});
        cxv        = $signed({2'b00, po_reg[0].w, 3'b000});
        r2_next    = po_reg[0];
        r2_next.p1 = PW'(po_reg[0].cos_pos ? cyv : -cyv) * PW'(po_reg[0].c);
        r2_next.p2 = PW'(po_reg[0].sin_pos ? cxv : -cxv) * PW'(po_reg[0].s);
    end

    always_comb
    begin
        r3_next   = po_reg[1];
        r3_next.t = TW'(po_reg[1].p1) + TW'(po_reg[1].p2);
    end

    always_comb
    begin
        r4_next    = po_reg[2];
        r4_next.st = STW'(po_reg[2].s) * STW'(po_reg[2].t);
        r4_next.ct = STW'(po_reg[2].c) * STW'(po_reg[2].t);
    end

    // Final stage: endpoints for every direction kind, then saturation.
    always_comb
    begin
        logic signed [EW-1:0] cx, cy, w16, h16, hm, wm, ex, ey;
        logic signed [STW-1:0] rx, ry;
        cx  = EW'($signed({1'b0, po_reg[3].w, 3'b000}));
        cy  = EW'($signed({1'b0, po_reg[3].h, 3'b000}));
        w16 = EW'($signed({1'b0, po_reg[3].w, 4'b0000}));
        h16 = EW'($signed({1'b0, po_reg[3].h, 4'b0000}));
        hm  = EW'($signed({1'b0, po_reg[3].qh}));
        wm  = EW'($signed({1'b0, po_reg[3].qw}));
        rx  = (po_reg[3].st + RND) >>> 30;
        ry  = (po_reg[3].ct + RND) >>> 30;
        ex  = cx + EW'(rx);
        ey  = cy - EW'(ry);
        sx_next = '0;
        sy_next = '0;
        ex_next = '0;
        ey_next = '0;
        gv_next = po_reg[3].ok;
        if (po_reg[3].ok)
        begin
            unique case (po_reg[3].dir)
                DIR_TOP:      sy_next = sat(h16);
                DIR_BOTTOM:   ey_next = sat(h16);
                DIR_LEFT:     sx_next = sat(w16);
                DIR_RIGHT:    ex_next = sat(w16);
                DIR_TOPRIGHT:
                begin
                    sx_next = sat(w16 - hm);
                    sy_next = sat(wm);
                    ex_next = sat(w16);
                end
                DIR_TOPLEFT:
                begin
                    sx_next = sat(hm);
                    sy_next = sat(wm);
                end
                DIR_BOTRIGHT:
                begin
                    ex_next = sat(hm);
                    ey_next = sat(wm);
                end
                DIR_BOTLEFT:
                begin
                    sx_next = sat(w16);
                    ex_next = sat(w16 - hm);
                    ey_next = sat(wm);
                end
                default:
                begin
                    ex_next = sat(ex);
                    ey_next = sat(ey);
                    sx_next = sat(w16 - ex);
                    sy_next = sat(h16 - ey);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            v_it_reg[0] <= 1'b0;
            v_po_reg[0] <= 1'b0;
            v_po_reg[1] <= 1'b0;
            v_po_reg[2] <= 1'b0;
            v_po_reg[3] <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else if (adv)
        begin
            va_reg      <= in_valid;
            vb_reg      <= va_reg;
            v_it_reg[0] <= vb_reg;
            v_po_reg[0] <= v_it_reg[NS];
            v_po_reg[1] <= v_po_reg[0];
            v_po_reg[2] <= v_po_reg[1];
            v_po_reg[3] <= v_po_reg[2];
            out_v_reg   <= v_po_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg.ok      <= cls.ok;
            a_reg.dir     <= cls.dir;
            a_reg.sin_pos <= cls.sin_pos;
            a_reg.cos_pos <= cls.cos_pos;
            a_reg.ang     <= cls.ang;
            a_reg.w       <= w;
            a_reg.h       <= h;
            a_reg.neg     <= 1'b0;
            a_reg.b       <= '0;
            a_reg.wh      <= '0;
            a_reg.den     <= '0;
            b_reg         <= b_next;
            it_reg[0]     <= c_next;
            po_reg[0]     <= r1_next;
            po_reg[1]     <= r2_next;
            po_reg[2]     <= r3_next;
            po_reg[3]     <= r4_next;
            gradient_valid <= gv_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            ex_reg        <= ex_next;
            ey_reg        <= ey_next;
        end
    end

    assign start_x = sx_reg;
    assign start_y = sy_reg;
    assign end_x   = ex_reg;
    assign end_y   = ey_reg;

endmodule

`default_nettype wire

// ----- sv/linear_gradient_line_endpoints_core.sv -----
// Linear gradient line endpoints: top level; depends on lgle_pkg, lgle_front,
// lgle_queue and lgle_back.
// An item passes the front register, the queue, stages A, B and C, the CORDIC and
// divider stages, R1 to R4 and the result register.
// Throughput: one beat per cycle unless a result waits unpopped; one step per stage.
// Reset: rst_n clears all valid flags at once; no clearing pass, ready right after.
`timescale 1ns / 1ps
`default_nettype none

module linear_gradient_line_endpoints_core
    import lgle_pkg::*;
#(
    parameter int SIZE_BITS              = SIZE_BITS_DEF,
    parameter int ANGLE_STEPS_PER_DEGREE = ANGLE_STEPS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [KIND_W-1:0]    kind,
    input  wire logic [SIZE_W-1:0]    box_width,
    input  wire logic [SIZE_W-1:0]    box_height,
    input  wire logic [ANGLE_W-1:0]   angle,
    input  wire logic [COUNT_W-1:0]   color_count,
    input  wire logic [COUNT_W-1:0]   stop_count,
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      gradient_valid,
    output logic signed [COORD_W-1:0] start_x,
    output logic signed [COORD_W-1:0] start_y,
    output logic signed [COORD_W-1:0] end_x,
    output logic signed [COORD_W-1:0] end_y
);

    // The queue carries the classified item together with the clamped box size.
    localparam int QW = $bits(cls_t) + 2 * SIZE_BITS;

    logic                 q_full, q_push, q_valid, q_pop;
    cls_t                 f_cls, b_cls;
    logic [SIZE_BITS-1:0] f_w, f_h, b_w, b_h;
    logic [QW-1:0]        q_rdata;

    // Front end: one register stage. It checks the color and stop counts,
    // forces a zero width or height to one, maps unknown kinds to the angle
    // kind and brings the angle into a single turn. It stalls only when the
    // queue behind it is full, so it keeps taking beats while a finished
    // result sits on the output.
    lgle_front #(
        .SIZE_BITS              (SIZE_BITS),
        .ANGLE_STEPS_PER_DEGREE (ANGLE_STEPS_PER_DEGREE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .box_width   (box_width),
        .box_height  (box_height),
        .angle       (angle),
        .color_count (color_count),
        .stop_count  (stop_count),
        .q_full      (q_full),
        .q_push      (q_push),
        .cls         (f_cls),
        .w           (f_w),
        .h           (f_h)
    );

    // A short queue decouples the two halves, so a stall of the output
    // reaches the input only after the queue has filled.
    lgle_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_push),
        .wr_data   ({f_cls, f_w, f_h}),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (q_rdata),
        .not_empty (q_valid)
    );

    assign {b_cls, b_w, b_h} = q_rdata;

    // Back end: a lockstep pipeline. Every item, whatever its kind, runs
    // through the CORDIC rotation and both corner dividers, so results leave
    // in arrival order. The pipeline halts as a whole only while its output
    // register holds a result that has not been popped.
    lgle_back #(
        .SIZE_BITS              (SIZE_BITS),
        .ANGLE_STEPS_PER_DEGREE (ANGLE_STEPS_PER_DEGREE)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (q_valid),
        .in_take        (q_pop),
        .cls            (b_cls),
        .w              (b_w),
        .h              (b_h),
        .empty          (empty),
        .pop            (pop),
        .gradient_valid (gradient_valid),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y)
    );

endmodule

`default_nettype wire

// ----- sv/lgle_checker.sv -----
// Port-level checks of the gradient line endpoint core, bound to the top level.
// Depends on lgle_pkg and linear_gradient_line_endpoints_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_gradient_line_endpoints_core_macros.svh"

module lgle_checker
    import lgle_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      full,
    input wire logic                      empty,
    input wire logic                      pop,
    input wire logic                      gradient_valid,
    input wire logic signed [COORD_W-1:0] start_x,
    input wire logic signed [COORD_W-1:0] start_y,
    input wire logic signed [COORD_W-1:0] end_x,
    input wire logic signed [COORD_W-1:0] end_y
);

    // An invalid result carries a zero line.
    `LGLE_AST_NOW(a_invalid_zero, clk, rst_n, !empty && !gradient_valid, start_x == '0 && start_y == '0 && end_x == '0 && end_y == '0, "invalid result with nonzero coordinates")
    // During reset both sides show an idle queue.
    `LGLE_AST_ALWAYS(a_reset_idle, clk, !rst_n, empty && !full, "queue not idle in reset")
    // A waiting result stays until it is popped.
    `LGLE_AST_NEXT(a_hold_valid, clk, rst_n, !empty && !pop, !empty, "result dropped before pop")
    `LGLE_AST_NEXT(a_hold_data, clk, rst_n, !empty && !pop, $stable(start_x) && $stable(end_y), "waiting result changed")

endmodule

bind linear_gradient_line_endpoints_core lgle_checker u_lgle_checker (.*);

`default_nettype wire
